// ===== design/xtl_pkg.sv =====
// Package for the streaming XML token lexer: character codes, token and
// error codes, lexer modes, the event record and the per-byte lex function.
// No dependencies.
`default_nettype none

package xtl_pkg;

  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_QUOTE = 8'h22;  // '"'

  localparam int unsigned MaxEvents = 4;

  typedef enum logic [2:0] {
    TOK_OPEN      = 3'd0,
    TOK_CLOSE_OPEN = 3'd1,
    TOK_SELF_CLOSE = 3'd2,
    TOK_END_BRACKET = 3'd3,
    TOK_SYMBOL    = 3'd4,
    TOK_STRING    = 3'd5,
    TOK_WORD      = 3'd6,
    TOK_FINAL     = 3'd7
  } tok_class_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_SLASH     = 2'd1,
    ERR_UNDEFINED = 2'd2,
    ERR_OPEN_STR  = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_LT     = 3'd1,
    MODE_SLASH  = 3'd2,
    MODE_STRING = 3'd3,
    MODE_WORD   = 3'd4,
    MODE_ERROR  = 3'd5
  } mode_e;

  typedef struct packed {
    tok_class_e cls;
    logic [7:0] data;
    logic       has_byte;
    logic       ends_token;
    err_e       err;
  } evt_t;

  // Result of one byte outside any pending token
  typedef struct packed {
    logic  valid;
    evt_t  evt;
    mode_e mode;
  } plain_t;

  typedef struct packed {
    evt_t [MaxEvents-1:0] evt;
    logic [2:0]           cnt;
    mode_e                mode;
  } lex_res_t;

  function automatic evt_t mk_evt(tok_class_e cls, logic [7:0] data, logic hb,
                                  logic done, err_e err);
    evt_t e;
    e.cls        = cls;
    e.data       = data;
    e.has_byte   = hb;
    e.ends_token = done;
    e.err        = err;
    return e;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic plain_t lex_plain(logic [7:0] c);
    plain_t p;
    p.valid = 1'b0;
    p.evt   = '0;
    p.mode  = MODE_NORMAL;
    if (is_space(c)) begin
      p.mode = MODE_NORMAL;
    end else if (c == CH_LT) begin
      p.mode = MODE_LT;
    end else if (c == CH_SLASH) begin
      p.mode = MODE_SLASH;
    end else if (c == CH_GT) begin
      p.valid = 1'b1;
      p.evt   = mk_evt(TOK_END_BRACKET, 8'h00, 1'b0, 1'b1, ERR_NONE);
    end else if (c == CH_EQ) begin
      p.valid = 1'b1;
      p.evt   = mk_evt(TOK_SYMBOL, c, 1'b1, 1'b1, ERR_NONE);
    end else if (c == CH_QUOTE) begin
      p.mode = MODE_STRING;
    end else if (is_alnum(c)) begin
      p.valid = 1'b1;
      p.evt   = mk_evt(TOK_WORD, c, 1'b1, 1'b0, ERR_NONE);
      p.mode  = MODE_WORD;
    end else begin
      p.valid = 1'b1;
      p.evt   = mk_evt(TOK_OPEN, 8'h00, 1'b0, 1'b0, ERR_UNDEFINED);
      p.mode  = MODE_ERROR;
    end
    return p;
  endfunction

  // All events caused by one byte, in order, plus the next mode
  function automatic lex_res_t lex_step(mode_e mode, logic [7:0] c, logic eot);
    lex_res_t r;
    plain_t   p;
    logic     run_plain;
    r.evt     = '0;
    r.cnt     = 3'd0;
    r.mode    = mode;
    run_plain = 1'b0;
    case (mode)
      MODE_LT: begin
        r.mode = MODE_NORMAL;
        if (c == CH_SLASH) begin
          r.evt[r.cnt[1:0]] = mk_evt(TOK_CLOSE_OPEN, 8'h00, 1'b0, 1'b1, ERR_NONE);
          r.cnt = r.cnt + 3'd1;
        end else begin
          r.evt[r.cnt[1:0]] = mk_evt(TOK_OPEN, 8'h00, 1'b0, 1'b1, ERR_NONE);
          r.cnt = r.cnt + 3'd1;
          run_plain = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (c == CH_GT) begin
          r.evt[r.cnt[1:0]] = mk_evt(TOK_SELF_CLOSE, 8'h00, 1'b0, 1'b1, ERR_NONE);
          r.mode = MODE_NORMAL;
        end else begin
          r.evt[r.cnt[1:0]] = mk_evt(TOK_OPEN, 8'h00, 1'b0, 1'b0, ERR_SLASH);
          r.mode = MODE_ERROR;
        end
        r.cnt = r.cnt + 3'd1;
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          r.evt[r.cnt[1:0]] = mk_evt(TOK_STRING, 8'h00, 1'b0, 1'b1, ERR_NONE);
          r.mode = MODE_NORMAL;
        end else begin
          r.evt[r.cnt[1:0]] = mk_evt(TOK_STRING, c, 1'b1, 1'b0, ERR_NONE);
        end
        r.cnt = r.cnt + 3'd1;
      end
      MODE_WORD: begin
        if (is_alnum(c)) begin
          r.evt[r.cnt[1:0]] = mk_evt(TOK_WORD, c, 1'b1, 1'b0, ERR_NONE);
          r.cnt = r.cnt + 3'd1;
        end else begin
          r.evt[r.cnt[1:0]] = mk_evt(TOK_WORD, 8'h00, 1'b0, 1'b1, ERR_NONE);
          r.cnt = r.cnt + 3'd1;
          run_plain = 1'b1;
        end
      end
      MODE_ERROR: begin
        r.mode = MODE_ERROR;
      end
      default: begin
        run_plain = 1'b1;
      end
    endcase

    // A terminating byte is lexed again from the normal mode
    if (run_plain) begin
      p = lex_plain(c);
      r.mode = p.mode;
      if (p.valid) begin
        r.evt[r.cnt[1:0]] = p.evt;
        r.cnt = r.cnt + 3'd1;
      end
    end

    if (eot) begin
      case (r.mode)
        MODE_LT: begin
          r.evt[r.cnt[1:0]] = mk_evt(TOK_OPEN, 8'h00, 1'b0, 1'b1, ERR_NONE);
          r.cnt = r.cnt + 3'd1;
        end
        MODE_SLASH: begin
          r.evt[r.cnt[1:0]] = mk_evt(TOK_OPEN, 8'h00, 1'b0, 1'b0, ERR_SLASH);
          r.cnt = r.cnt + 3'd1;
        end
        MODE_STRING: begin
          r.evt[r.cnt[1:0]] = mk_evt(TOK_OPEN, 8'h00, 1'b0, 1'b0, ERR_OPEN_STR);
          r.cnt = r.cnt + 3'd1;
        end
        MODE_WORD: begin
          r.evt[r.cnt[1:0]] = mk_evt(TOK_WORD, 8'h00, 1'b0, 1'b1, ERR_NONE);
          r.cnt = r.cnt + 3'd1;
        end
        default: begin
          r.cnt = r.cnt;
        end
      endcase
      r.evt[r.cnt[1:0]] = mk_evt(TOK_FINAL, 8'h00, 1'b0, 1'b1, ERR_NONE);
      r.cnt  = r.cnt + 3'd1;
      r.mode = MODE_NORMAL;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/xtl_if.sv =====
// Valid/ready channel interfaces of the XML token lexer: the byte input
// channel and the token event channel. No dependencies.
`default_nettype none

interface xtl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface xtl_token_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_class;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       ends_token;
  logic [1:0] error_code;
  logic       last_of_run;

  modport source (output valid, output token_class, output data_byte,
                  output has_byte, output ends_token, output error_code,
                  output last_of_run, input ready);
  modport sink (input valid, input token_class, input data_byte,
                input has_byte, input ends_token, input error_code,
                input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== design/xml_token_lexer.sv =====
// Streaming XML token lexer, top level.
// Depends on xtl_pkg and the channel interfaces in xtl_if.sv.
//
// Usage: text bytes come in on byte_i (char_in, end_of_text on the last
// byte); token events leave on token_o, one event per transfer. A byte
// causes zero to four events; last_of_run marks the last one of a byte.
// The byte is lexed against the current mode in the cycle it is taken and
// its events land in a four-entry event register; the first event is
// offered on token_o in the next cycle.
// Throughput: one byte per cycle while each byte yields at most one event
// and token_o accepts every event. A byte with events holds the input
// until the single output port has drained the event register, one entry
// per cycle while token_o is ready. A new byte is taken in the same cycle
// the last pending event transfers, so the stream has no bubbles. Bytes
// with no events (whitespace, quote, '<') do not hold the input.
// When token_o stalls, the current event holds and byte_i ready stays low
// until the last pending event of the byte transfers.
// Reset: asynchronous, active low; clears the lexer mode to normal and
// empties the event register.
`default_nettype none

module xml_token_lexer (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  xtl_byte_if.sink    byte_i,
  xtl_token_if.source token_o
);
  import xtl_pkg::*;

  mode_e                mode_q;
  logic [2:0]           cnt_q, idx_q;
  evt_t [MaxEvents-1:0] evt_q;
  lex_res_t             lex;
  evt_t                 cur;
  logic                 in_xfer, out_xfer, pend_empty, pend_last;

  assign lex = lex_step(mode_q, byte_i.char_in, byte_i.end_of_text);

  assign pend_empty = (idx_q == cnt_q);
  assign pend_last  = ((idx_q + 3'd1) == cnt_q);

  assign token_o.valid = !pend_empty;
  assign out_xfer      = token_o.valid && token_o.ready;
  assign byte_i.ready  = pend_empty || (pend_last && token_o.ready);
  assign in_xfer       = byte_i.valid && byte_i.ready;

  assign cur                 = evt_q[idx_q[1:0]];
  assign token_o.token_class = cur.cls;
  assign token_o.data_byte   = cur.data;
  assign token_o.has_byte    = cur.has_byte;
  assign token_o.ends_token  = cur.ends_token;
  assign token_o.error_code  = cur.err;
  assign token_o.last_of_run = pend_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      cnt_q  <= 3'd0;
      idx_q  <= 3'd0;
    end else if (in_xfer) begin
      mode_q <= lex.mode;
      cnt_q  <= lex.cnt;
      idx_q  <= 3'd0;
    end else if (out_xfer) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  // Event payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      evt_q <= lex.evt;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_xml_token_lexer.sv =====
// Testbench for xml_token_lexer: directed and random texts, checked event by event
// against a predictor of the lexer kept in a small scoreboard class.
// Depends on xtl_pkg, the channel interfaces in xtl_if.sv and the lexer RTL.

module tb_xml_token_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  import xtl_pkg::*;

  typedef struct packed {
    tok_class_e cls;
    logic [7:0] data;
    logic       has_byte;
    logic       ends_token;
    err_e       err;
    logic       last;
  } token_evt_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eot;
  } text_byte_t;

  class token_scoreboard;
    mode_e       mode;
    token_evt_t  expected_q[$];
    int unsigned n_bytes;
    int unsigned n_texts;
    int unsigned n_events;
    int unsigned n_err_events;
    int unsigned n_fails;
    logic [7:0]  classes_seen;

    function new();
      mode         = MODE_NORMAL;
      n_bytes      = 0;
      n_texts      = 0;
      n_events     = 0;
      n_err_events = 0;
      n_fails      = 0;
      classes_seen = '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function bit blank_byte(logic [7:0] c);
      return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function bit name_byte(logic [7:0] c);
      return (c inside {[8'h30:8'h39]}) || (c inside {[8'h41:8'h5A]}) ||
             (c inside {[8'h61:8'h7A]});
    endfunction

    function void add(tok_class_e cls, logic [7:0] data, logic hb, logic done, err_e err);
      token_evt_t e;
      e.cls        = cls;
      e.data       = data;
      e.has_byte   = hb;
      e.ends_token = done;
      e.err        = err;
      e.last       = 1'b0;
      expected_q.push_back(e);
    endfunction

    // Byte seen with no token pending
    function void lex_fresh(logic [7:0] c);
      mode = MODE_NORMAL;
      if (blank_byte(c)) return;
      case (c)
        CH_LT:    mode = MODE_LT;
        CH_SLASH: mode = MODE_SLASH;
        CH_QUOTE: mode = MODE_STRING;
        CH_GT:    add(TOK_END_BRACKET, 8'h00, 1'b0, 1'b1, ERR_NONE);
        CH_EQ:    add(TOK_SYMBOL, c, 1'b1, 1'b1, ERR_NONE);
        default: begin
          if (name_byte(c)) begin
            add(TOK_WORD, c, 1'b1, 1'b0, ERR_NONE);
            mode = MODE_WORD;
          end else begin
            add(TOK_OPEN, 8'h00, 1'b0, 1'b0, ERR_UNDEFINED);
            mode = MODE_ERROR;
          end
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] c, logic eot);
      int unsigned first;
      first = expected_q.size();
      n_bytes++;
      case (mode)
        MODE_LT: begin
          if (c == CH_SLASH) begin
            add(TOK_CLOSE_OPEN, 8'h00, 1'b0, 1'b1, ERR_NONE);
            mode = MODE_NORMAL;
          end else begin
            add(TOK_OPEN, 8'h00, 1'b0, 1'b1, ERR_NONE);
            lex_fresh(c);
          end
        end
        MODE_SLASH: begin
          if (c == CH_GT) begin
            add(TOK_SELF_CLOSE, 8'h00, 1'b0, 1'b1, ERR_NONE);
            mode = MODE_NORMAL;
          end else begin
            add(TOK_OPEN, 8'h00, 1'b0, 1'b0, ERR_SLASH);
            mode = MODE_ERROR;
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            add(TOK_STRING, 8'h00, 1'b0, 1'b1, ERR_NONE);
            mode = MODE_NORMAL;
          end else begin
            add(TOK_STRING, c, 1'b1, 1'b0, ERR_NONE);
          end
        end
        MODE_WORD: begin
          if (name_byte(c)) begin
            add(TOK_WORD, c, 1'b1, 1'b0, ERR_NONE);
          end else begin
            // terminator is lexed again from scratch
            add(TOK_WORD, 8'h00, 1'b0, 1'b1, ERR_NONE);
            lex_fresh(c);
          end
        end
        MODE_ERROR: ;
        default: lex_fresh(c);
      endcase
      if (eot) begin
        n_texts++;
        case (mode)
          MODE_LT:     add(TOK_OPEN, 8'h00, 1'b0, 1'b1, ERR_NONE);
          MODE_SLASH:  add(TOK_OPEN, 8'h00, 1'b0, 1'b0, ERR_SLASH);
          MODE_STRING: add(TOK_OPEN, 8'h00, 1'b0, 1'b0, ERR_OPEN_STR);
          MODE_WORD:   add(TOK_WORD, 8'h00, 1'b0, 1'b1, ERR_NONE);
          default: ;
        endcase
        add(TOK_FINAL, 8'h00, 1'b0, 1'b1, ERR_NONE);
        mode = MODE_NORMAL;
      end
      if (expected_q.size() > first) expected_q[expected_q.size()-1].last = 1'b1;
    endfunction

    function void flag(string field, logic [7:0] want, logic [7:0] got);
      n_fails++;
      $display("%0t: %s mismatch, expected %h got %h", $time, field, want, got);
    endfunction

    function void check_token(logic [2:0] cls, logic [7:0] data, logic hb, logic done,
                              logic [1:0] err, logic last);
      token_evt_t want;
      if (expected_q.size() == 0) begin
        n_fails++;
        $display("%0t: token event with none expected, expected none got class %h",
                 $time, cls);
        return;
      end
      want = expected_q.pop_front();
      n_events++;
      classes_seen[want.cls] = 1'b1;
      if (want.err != ERR_NONE) n_err_events++;
      if (cls !== want.cls)         flag("token_class", 8'(want.cls), 8'(cls));
      if (data !== want.data)       flag("data_byte", want.data, data);
      if (hb !== want.has_byte)     flag("has_byte", 8'(want.has_byte), 8'(hb));
      if (done !== want.ends_token) flag("ends_token", 8'(want.ends_token), 8'(done));
      if (err !== want.err)         flag("error_code", 8'(want.err), 8'(err));
      if (last !== want.last)       flag("last_of_run", 8'(want.last), 8'(last));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic hold_off;
  int unsigned rx_cycle;
  int unsigned rx_style;

  xtl_byte_if  byte_if ();
  xtl_token_if token_if ();

  xml_token_lexer u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .token_o (token_if)
  );

  token_scoreboard lexer_sb = new();

  text_byte_t stim_q[$];
  logic [7:0] text_buf[$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------- text generation ----------------

  function automatic void put(logic [7:0] c);
    text_buf.push_back(c);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void close_text();
    text_byte_t t;
    foreach (text_buf[i]) begin
      t.c   = text_buf[i];
      t.eot = (i == text_buf.size() - 1);
      stim_q.push_back(t);
    end
    text_buf.delete();
  endfunction

  function automatic void put_spaces();
    logic [7:0] c;
    repeat ($urandom_range(0, 2)) begin
      c = 8'($urandom_range(9, 14));
      if (c == 8'd14) c = 8'h20;
      put(c);
    end
  endfunction

  function automatic string rand_name();
    string pool;
    string s;
    int    idx;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    s    = "";
    repeat ($urandom_range(1, 5)) begin
      idx = $urandom_range(0, pool.len() - 1);
      s   = {s, pool.substr(idx, idx)};
    end
    return s;
  endfunction

  function automatic void put_element();
    string nm;
    logic [7:0] c;
    nm = rand_name();
    put_spaces();
    put(CH_LT);
    put_str(nm);
    repeat ($urandom_range(0, 2)) begin
      put(8'h20);
      put_spaces();
      put_str(rand_name());
      put_spaces();
      put(CH_EQ);
      put_spaces();
      put(CH_QUOTE);
      repeat ($urandom_range(0, 5)) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_QUOTE) c = 8'h51;
        put(c);
      end
      put(CH_QUOTE);
    end
    put_spaces();
    if ($urandom_range(0, 2) == 0) begin
      put(CH_SLASH);
      put(CH_GT);
    end else begin
      put(CH_GT);
      put_spaces();
      if ($urandom_range(0, 1) == 1) put_str(rand_name());
      put_spaces();
      put(CH_LT);
      put(CH_SLASH);
      put_str(nm);
      put_spaces();
      put(CH_GT);
    end
  endfunction

  function automatic void build_texts();
    string       specials;
    int unsigned kind;
    int unsigned keep;
    int unsigned idx;
    specials = "<>/=\" a9Z";

    // directed: word at end of text after '<', close tag, string with
    // extreme bytes, lone slash, undefined byte, open string, slash at end, '<<'
    put_str("<a");                 close_text();
    put_str("</b>"); put(8'h09);   close_text();
    put_str("x=\"Z"); put(8'hFF); put(8'h00); put_str("\"/>"); close_text();
    put_str("/q"); put(8'hFF);     close_text();
    put(8'h00); put(8'h20);        close_text();
    put_str("\"k");                close_text();
    put(CH_SLASH);                 close_text();
    put_str("<<");                 close_text();

    while (stim_q.size() < 310) begin
      kind = $urandom_range(0, 9);
      if (kind <= 7) begin
        repeat ($urandom_range(1, 3)) put_element();
        put_spaces();
        if (kind == 6 && text_buf.size() > 1) begin
          // cut off mid-document
          keep = $urandom_range(1, text_buf.size() - 1);
          while (text_buf.size() > keep) void'(text_buf.pop_back());
        end else if (kind == 7) begin
          idx = $urandom_range(0, text_buf.size() - 1);
          text_buf[idx] = 8'($urandom_range(0, 255));
        end
      end else begin
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 1) == 1) put(8'($urandom_range(0, 255)));
          else put(specials[$urandom_range(0, specials.len() - 1)]);
        end
      end
      if (text_buf.size() == 0) put(8'h20);
      close_text();
    end
  endfunction

  // ---------------- receiver ----------------

  always @(posedge clk_i) begin
    if (rst_ni && token_if.valid && token_if.ready)
      lexer_sb.check_token(token_if.token_class, token_if.data_byte, token_if.has_byte,
                           token_if.ends_token, token_if.error_code, token_if.last_of_run);
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_style <= $urandom_range(0, 3);
    case (rx_style)
      0:       token_if.ready <= !hold_off;
      1:       token_if.ready <= !hold_off && ($urandom_range(0, 1) == 1);
      2:       token_if.ready <= !hold_off && ($urandom_range(0, 6) != 0);
      default: token_if.ready <= !hold_off && (rx_cycle % 3 == 0);
    endcase
  end

  // long receiver hold-off so the event register fills and byte_i stalls
  initial begin
    while (lexer_sb.n_bytes < 150) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #200000;
    $display("%0t: timeout with %0d events outstanding", $time, lexer_sb.pending());
    $display("xml_token_lexer regression: fail");
    $finish;
  end

  // ---------------- sender and run control ----------------

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    rst_ni               = 1'b0;
    hold_off             = 1'b0;
    rx_cycle             = 0;
    rx_style             = 0;
    byte_if.valid        = 1'b0;
    byte_if.char_in      = 8'h00;
    byte_if.end_of_text  = 1'b0;
    token_if.ready       = 1'b0;
    burst_left           = 0;
    build_texts();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_q[i]) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = 40;
          gap        = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) :
                                                     $urandom_range(0, 3);
        end
        if (gap != 0) begin
          byte_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      byte_if.valid       <= 1'b1;
      byte_if.char_in     <= stim_q[i].c;
      byte_if.end_of_text <= stim_q[i].eot;
      do @(posedge clk_i); while (!byte_if.ready);
      lexer_sb.note_byte(stim_q[i].c, stim_q[i].eot);
      burst_left--;
    end
    byte_if.valid <= 1'b0;

    while (lexer_sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Lexed %0d bytes in %0d texts; %0d token events checked, %0d of them errors.",
             lexer_sb.n_bytes, lexer_sb.n_texts, lexer_sb.n_events, lexer_sb.n_err_events);
    $display("Token classes seen (bit per class): %b, one long output stall included.",
             lexer_sb.classes_seen);
    if (lexer_sb.n_fails == 0) begin
      $display("xml_token_lexer regression: pass");
    end else begin
      $display("xml_token_lexer regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/xtl_pkg.sv
design/xtl_if.sv
design/xml_token_lexer.sv
test/tb_xml_token_lexer.sv
